/* hw/rtl/keyed_min_max_sum_aggregator_assert.svh */
// assertion macros for the keyed aggregator
`ifndef KEYED_MIN_MAX_SUM_AGGREGATOR_ASSERT_SVH
`define KEYED_MIN_MAX_SUM_AGGREGATOR_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define KMMS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication check failed");

// antecedent implies consequent in the next cycle
`define KMMS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* hw/rtl/kmms_pkg.sv */
// shared constants and types of the keyed aggregator
package kmms_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int NAME_MAX      = 64;
  localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
  localparam int LEN_W         = $clog2(NAME_MAX);
  localparam int VAL_LIMIT     = 9999;

  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  localparam logic [1:0] FR_INT   = 2'd0;
  localparam logic [1:0] FR_POINT = 2'd1;
  localparam logic [1:0] FR_DIGIT = 2'd2;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_LONG      = 3'd2,
    ST_MALFORMED = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef struct packed {
    logic [LEN_W-1:0]   len;
    logic signed [14:0] min;
    logic signed [14:0] max;
    logic signed [47:0] sum;
    logic [31:0]        count;
  } stat_t;

  // controller to datapath
  typedef struct packed {
    logic acc_byte;
    logic start_nl;
    logic start_rd;
    logic stat_rd;
    logic lb_rd;
    logic cmp_rd;
    logic cpy_wr;
    logic idx_inc;
    logic next_slot;
    logic new_wr;
    logic upd_wr;
    logic out_rd;
    logic out_ld;
    logic err_ld;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_nl;
    logic nl_err;
    logic here_valid;
    logic len_eq;
    logic bytes_eq;
    logic idx_last;
    logic tries_last;
    logic out_free;
  } sts_t;

endpackage

/* hw/rtl/kmms_ctrl.sv */
// sequencer of the keyed aggregator: line handling, probing and output load
module kmms_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_op_i,
  input  kmms_pkg::sts_t  sts_i,
  output logic            in_ready_o,
  output kmms_pkg::cmd_t  cmd_o
);
  import kmms_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_STAT, S_CHECK, S_CPY_RD, S_CPY_WR, S_NEW_WR,
    S_CMP_RD, S_CMP_CHK, S_UPD_WR, S_OUT_RD, S_OUT_LD, S_ERR_LD
  } state_e;

  state_e state_q, state_d;
  logic   ready_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && ready_q) begin
          if (in_op_i) begin
            cmd_o.start_rd = 1'b1;
            state_d = S_OUT_RD;
          end else if (sts_i.is_nl) begin
            cmd_o.start_nl = 1'b1;
            state_d = sts_i.nl_err ? S_ERR_LD : S_RD_STAT;
          end else begin
            cmd_o.acc_byte = 1'b1;
          end
        end
      end
      S_RD_STAT: begin
        cmd_o.stat_rd = 1'b1;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (!sts_i.here_valid) begin
          state_d = S_CPY_RD;
        end else if (sts_i.len_eq) begin
          state_d = S_CMP_RD;
        end else begin
          cmd_o.next_slot = 1'b1;
          state_d = sts_i.tries_last ? S_ERR_LD : S_RD_STAT;
        end
      end
      S_CPY_RD: begin
        cmd_o.lb_rd = 1'b1;
        state_d = S_CPY_WR;
      end
      S_CPY_WR: begin
        cmd_o.cpy_wr  = 1'b1;
        cmd_o.idx_inc = 1'b1;
        state_d = sts_i.idx_last ? S_NEW_WR : S_CPY_RD;
      end
      S_NEW_WR: begin
        cmd_o.new_wr = 1'b1;
        state_d = S_OUT_RD;
      end
      S_CMP_RD: begin
        cmd_o.cmp_rd = 1'b1;
        state_d = S_CMP_CHK;
      end
      S_CMP_CHK: begin
        if (!sts_i.bytes_eq) begin
          cmd_o.next_slot = 1'b1;
          state_d = sts_i.tries_last ? S_ERR_LD : S_RD_STAT;
        end else if (sts_i.idx_last) begin
          state_d = S_UPD_WR;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d = S_CMP_RD;
        end
      end
      S_UPD_WR: begin
        cmd_o.upd_wr = 1'b1;
        state_d = S_OUT_RD;
      end
      S_OUT_RD: begin
        cmd_o.out_rd = 1'b1;
        state_d = S_OUT_LD;
      end
      S_OUT_LD: begin
        if (sts_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_ERR_LD: begin
        if (sts_i.out_free) begin
          cmd_o.err_ld = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ready_q <= (state_d == S_IDLE);
    end
  end

  assign in_ready_o = ready_q;

endmodule

/* hw/rtl/kmms_dp.sv */
// datapath of the keyed aggregator: line parser, table memories, output register
module kmms_dp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  kmms_pkg::cmd_t  cmd_i,
  input  logic [7:0]      data_byte_i,
  input  logic [7:0]      entry_index_i,
  input  logic [5:0]      char_index_i,
  output kmms_pkg::sts_t  sts_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            out_kind_o,
  output logic [135:0]    out_data_o
);
  import kmms_pkg::*;
  `include "keyed_min_max_sum_aggregator_assert.svh"

  // line state
  logic [LEN_W-1:0] nlen_q;
  logic             in_val_q, neg_q, dig_q;
  logic [13:0]      acc_q;
  logic [1:0]       frac_q;
  status_e          lerr_q;
  logic [7:0]       b0_q, b1_q, c2_q, c1_q;

  logic [7:0] lb_mem [NAME_MAX];
  logic [7:0] lb_rd_q;

  // probe state
  logic [LEN_W-1:0]   cur_len_q, idx_q, ci_q;
  logic signed [14:0] v_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [SLOT_W:0]    tries_q;
  logic               kind_q;
  status_e            status_q;

  logic [TABLE_ENTRIES-1:0] valid_q;
  stat_t      st_mem [TABLE_ENTRIES];
  stat_t      st_rd_q;
  logic [7:0] nm_mem [TABLE_ENTRIES*NAME_MAX];
  logic [7:0] nm_rd_q;

  logic         out_valid_q, out_kind_q;
  logic [135:0] out_data_q;

  logic [17:0] acc_x10;
  logic [17:0] acc_next;
  logic [17:0] mag_x10;
  logic [13:0] mag;
  logic signed [14:0] v_new;
  logic [31:0] hash;
  status_e     nl_status;
  logic signed [48:0] sum_ext;
  logic signed [47:0] sum_sat;
  stat_t       st_upd;
  logic [SLOT_W+LEN_W-1:0] nm_raddr;
  logic        out_free;

  assign acc_x10  = {4'd0, acc_q} * 18'd10;
  assign acc_next = acc_x10 + {10'd0, data_byte_i - CH_ZERO};
  assign mag_x10  = acc_x10;
  assign mag = (frac_q == FR_DIGIT) ? acc_q :
               ((mag_x10 > 18'(VAL_LIMIT)) ? 14'(VAL_LIMIT) : mag_x10[13:0]);
  assign v_new = neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

  assign hash = ({24'd0, b0_q - CH_A} << 24) + ({24'd0, b1_q - CH_A} << 16)
              + ({24'd0, c2_q - CH_A} << 8) + {24'd0, c1_q - CH_A};

  always_comb begin
    priority if (lerr_q != ST_OK) nl_status = lerr_q;
    else if (!in_val_q || !dig_q) nl_status = ST_MALFORMED;
    else nl_status = ST_OK;
  end

  // statistics update for a matching slot
  assign sum_ext = {st_rd_q.sum[47], st_rd_q.sum} + 49'(v_q);
  always_comb begin
    priority if (sum_ext > 49'sh0_7FFF_FFFF_FFFF) sum_sat = 48'sh7FFF_FFFF_FFFF;
    else if (sum_ext < -49'sh0_8000_0000_0000) sum_sat = 48'sh8000_0000_0000;
    else sum_sat = sum_ext[47:0];
    st_upd       = st_rd_q;
    st_upd.min   = (v_q < st_rd_q.min) ? v_q : st_rd_q.min;
    st_upd.max   = (v_q > st_rd_q.max) ? v_q : st_rd_q.max;
    st_upd.sum   = sum_sat;
    st_upd.count = (st_rd_q.count == '1) ? st_rd_q.count : st_rd_q.count + 32'd1;
  end

  // line parser
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nlen_q <= '0; in_val_q <= 1'b0; neg_q <= 1'b0; dig_q <= 1'b0;
      acc_q <= '0; frac_q <= FR_INT; lerr_q <= ST_OK;
      b0_q <= '0; b1_q <= '0; c2_q <= '0; c1_q <= '0;
    end else if (cmd_i.start_nl) begin
      nlen_q <= '0; in_val_q <= 1'b0; neg_q <= 1'b0; dig_q <= 1'b0;
      acc_q <= '0; frac_q <= FR_INT; lerr_q <= ST_OK;
      b1_q <= '0; c2_q <= '0;
    end else if (cmd_i.acc_byte) begin
      if (in_val_q) begin
        if (data_byte_i == CH_MINUS) begin
          if (!dig_q && frac_q == FR_INT && !neg_q) neg_q <= 1'b1;
          else if (lerr_q == ST_OK) lerr_q <= ST_MALFORMED;
        end else if (data_byte_i == CH_POINT) begin
          if (frac_q == FR_INT) frac_q <= FR_POINT;
          else if (lerr_q == ST_OK) lerr_q <= ST_MALFORMED;
        end else if (data_byte_i >= CH_ZERO && data_byte_i <= CH_ZERO + 8'd9) begin
          if (frac_q == FR_DIGIT) begin
            if (lerr_q == ST_OK) lerr_q <= ST_MALFORMED;
          end else begin
            acc_q <= (acc_next > 18'(VAL_LIMIT)) ? 14'(VAL_LIMIT) : acc_next[13:0];
            dig_q <= 1'b1;
            if (frac_q == FR_POINT) frac_q <= FR_DIGIT;
          end
        end else if (lerr_q == ST_OK) begin
          lerr_q <= ST_MALFORMED;
        end
      end else if (data_byte_i == CH_SEMI) begin
        if (nlen_q == '0 && lerr_q == ST_OK) lerr_q <= ST_EMPTY;
        in_val_q <= 1'b1;
      end else if (nlen_q < LEN_W'(NAME_MAX - 1)) begin
        nlen_q <= nlen_q + 1'b1;
        if (nlen_q == '0) begin
          b0_q <= data_byte_i;
          c2_q <= '0;
        end else begin
          c2_q <= c1_q;
        end
        if (nlen_q == LEN_W'(1)) b1_q <= data_byte_i;
        c1_q <= data_byte_i;
      end else if (lerr_q == ST_OK) begin
        lerr_q <= ST_LONG;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_byte && !in_val_q && data_byte_i != CH_SEMI &&
        nlen_q < LEN_W'(NAME_MAX - 1)) begin
      lb_mem[nlen_q] <= data_byte_i;
    end
    if (cmd_i.lb_rd || cmd_i.cmp_rd) lb_rd_q <= lb_mem[idx_q];
  end

  // probe control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      kind_q   <= 1'b0;
      status_q <= ST_OK;
      slot_q   <= '0;
      tries_q  <= '0;
      idx_q    <= '0;
    end else begin
      if (cmd_i.start_nl) begin
        kind_q    <= 1'b0;
        status_q  <= nl_status;
        slot_q    <= hash[SLOT_W-1:0];
        tries_q   <= '0;
        cur_len_q <= nlen_q;
        v_q       <= v_new;
        ci_q      <= char_index_i;
      end
      if (cmd_i.start_rd) begin
        kind_q   <= 1'b1;
        status_q <= ST_OK;
        slot_q   <= entry_index_i[SLOT_W-1:0];
        ci_q     <= char_index_i;
      end
      if (cmd_i.stat_rd) idx_q <= '0;
      if (cmd_i.idx_inc) idx_q <= idx_q + 1'b1;
      if (cmd_i.next_slot) begin
        if (tries_q == (SLOT_W+1)'(TABLE_ENTRIES - 1)) begin
          status_q <= ST_FULL;
        end else begin
          slot_q  <= slot_q + 1'b1;
          tries_q <= tries_q + 1'b1;
        end
      end
      if (cmd_i.new_wr) valid_q[slot_q] <= 1'b1;
    end
  end

  assign nm_raddr = cmd_i.out_rd ? {slot_q, ci_q} : {slot_q, idx_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.new_wr) begin
      st_mem[slot_q] <= '{len: cur_len_q, min: v_q, max: v_q,
                          sum: 48'(v_q), count: 32'd1};
    end else if (cmd_i.upd_wr) begin
      st_mem[slot_q] <= st_upd;
    end
    if (cmd_i.stat_rd || cmd_i.out_rd) st_rd_q <= st_mem[slot_q];
    if (cmd_i.cpy_wr) nm_mem[{slot_q, idx_q}] <= lb_rd_q;
    if (cmd_i.cmp_rd || cmd_i.out_rd) nm_rd_q <= nm_mem[nm_raddr];
  end

  // output register
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_ld || cmd_i.err_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.err_ld) begin
      out_kind_q <= kind_q;
      out_data_q <= {133'd0, status_q};
    end else if (cmd_i.out_ld) begin
      out_kind_q <= kind_q;
      if (valid_q[slot_q]) begin
        out_data_q <= {st_rd_q.count, st_rd_q.sum, st_rd_q.max, st_rd_q.min,
                       (ci_q < st_rd_q.len) ? nm_rd_q : 8'd0,
                       st_rd_q.len, 1'b1, slot_q, status_q};
      end else begin
        out_data_q <= {125'd0, slot_q, status_q};
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_data_o  = out_data_q;

  assign sts_o.is_nl      = (data_byte_i == CH_NL);
  assign sts_o.nl_err     = (nl_status != ST_OK);
  assign sts_o.here_valid = valid_q[slot_q];
  assign sts_o.len_eq     = (st_rd_q.len == cur_len_q);
  assign sts_o.bytes_eq   = (lb_rd_q == nm_rd_q);
  assign sts_o.idx_last   = (idx_q == cur_len_q - 1'b1);
  assign sts_o.tries_last = (tries_q == (SLOT_W+1)'(TABLE_ENTRIES - 1));
  assign sts_o.out_free   = out_free;

  `KMMS_ASSERT_IMP(a_copy_free_slot, cmd_i.cpy_wr, !valid_q[slot_q])
  `KMMS_ASSERT_IMP(a_upd_match, cmd_i.upd_wr, valid_q[slot_q] && st_rd_q.len == cur_len_q)
  `KMMS_ASSERT_IMP(a_load_free, cmd_i.out_ld || cmd_i.err_ld, out_free)
  `KMMS_ASSERT_NXT(a_new_valid, cmd_i.new_wr, valid_q[$past(slot_q)])

endmodule

/* hw/rtl/keyed_min_max_sum_aggregator.sv */
// top level of the keyed min/max/sum aggregator over name;value text lines
// a plain stream byte is taken in S_IDLE; a read beat passes S_OUT_RD, then S_OUT_LD
// a newline runs S_RD_STAT, S_CHECK per probed slot, S_CMP_RD, S_CMP_CHK or S_CPY_RD, S_CPY_WR
// per name byte, then a write and the result load; errors go to S_ERR_LD; output stalls hold the loads
// reset (async, active low) empties the table at once through per-slot valid flops
// and clears the line parser; no clearing pass is needed
module keyed_min_max_sum_aggregator (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // data_byte [7:0], entry_index [15:8], char_index [21:16], zero pad [23:22]
  input  logic [23:0]  s_axis_tdata,
  // operation [0]
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status [2:0], slot [10:3], entry_valid [11], name_length [17:12],
  // name_byte [25:18], min_tenths [40:26], max_tenths [55:41],
  // sum_tenths [103:56], line_count [135:104]
  output logic [135:0] m_axis_tdata,
  // result_kind [0]
  output logic         m_axis_tuser
);
  import kmms_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: one beat at a time, waits for the output register on results
  kmms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .sts_i      (sts),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  // parser, hash, table memories and result register
  kmms_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .data_byte_i   (s_axis_tdata[7:0]),
    .entry_index_i (s_axis_tdata[15:8]),
    .char_index_i  (s_axis_tdata[21:16]),
    .sts_o         (sts),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_kind_o    (m_axis_tuser),
    .out_data_o    (m_axis_tdata)
  );

endmodule
